### sv/pctd_pkg.sv
package pctd_pkg;

    // Table geometry and field widths.
    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int MAX_CODE_LEN  = 16;
    localparam int CODE_W        = 16;
    localparam int LEN_W         = 5;
    localparam int SYMBOL_BITS   = 8;
    localparam int SYM_W         = 8;
    localparam int INDEX_FIELD_W = 4;
    localparam int STATUS_W      = 2;

    // Item opcodes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DATA = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_SYMBOL   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_LEFTOVER = 2'd2;

    // One stored table entry.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  length;
        logic [SYM_W-1:0]  symbol;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Pending codeword handed to the compare unit.
    typedef struct packed {
        logic [CODE_W-1:0] bits;
        logic [LEN_W-1:0]  length;
    } pending_t;

endpackage

### sv/pctd_in_if.sv
interface pctd_in_if
    import pctd_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     opcode;
    logic [INDEX_FIELD_W-1:0] entry_index;
    logic [LEN_W-1:0]         entry_length;
    logic [CODE_W-1:0]        entry_code;
    logic [SYM_W-1:0]         entry_symbol;
    logic                     data_bit;
    logic                     stream_last;

    modport source (
        output valid, opcode, entry_index, entry_length, entry_code, entry_symbol,
               data_bit, stream_last,
        input  ready
    );

    modport sink (
        input  valid, opcode, entry_index, entry_length, entry_code, entry_symbol,
               data_bit, stream_last,
        output ready
    );
endinterface

### sv/pctd_out_if.sv
interface pctd_out_if
    import pctd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SYM_W-1:0]    symbol_out;
    logic [STATUS_W-1:0] status;
    logic                end_of_stream;

    modport source (
        output valid, symbol_out, status, end_of_stream,
        input  ready
    );

    modport sink (
        input  valid, symbol_out, status, end_of_stream,
        output ready
    );
endinterface

### sv/pctd_ram.sv
module pctd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### sv/pctd_cmp.sv
module pctd_cmp
    import pctd_pkg::*;
(
    input  entry_t   entry,
    input  logic     entry_valid,
    input  pending_t pending,
    output logic     hit
);

    logic [CODE_W-1:0] len_mask;
    logic              len_ok;

    // Only the low bits up to the entry length take part in the compare.
    assign len_mask = ~({CODE_W{1'b1}} << entry.length);

    // An entry of length zero or beyond the maximum never matches.
    assign len_ok = (entry.length != '0)
                 && (entry.length <= LEN_W'(MAX_CODE_LEN))
                 && (entry.length == pending.length);

    assign hit = entry_valid && len_ok && ((entry.code & len_mask) == pending.bits);

endmodule

### sv/prefix_code_table_decoder_core.sv
// Channel  Modport  Moves
// -------  -------  -----------------------------------------------
// cmd      sink     load items (table writes) and coded data bits
// res      source   decoded symbols, overflow and leftover reports
//
// A load item leaves the block in its idle state, so it stays ready. A data
// bit starts a scan: the transfer cycle issues the first table read, then
// one entry per cycle, unless a stalled result holds it, goes through the
// table RAM's single read port into the shared compare unit until a match
// or the last entry.
// Reset clears the valid marks and the pending codeword at once; there is
// no clearing pass. A stalled result holds the scan on its final entry.
module prefix_code_table_decoder_core
    import pctd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    pctd_in_if.sink    cmd,
    pctd_out_if.source res
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic                     state_reg, state_next;
    logic [IDX_W-1:0]         cnt_reg, cnt_next;
    pending_t                 pend_reg, pend_next;
    logic                     last_reg, last_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic                     out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]         out_sym_reg, out_sym_next;
    logic [STATUS_W-1:0]      out_stat_reg, out_stat_next;
    logic                     out_eos_reg, out_eos_next;

    logic             accept;
    logic             load_en;
    logic [IDX_W-1:0] rd_addr;
    entry_t           wr_entry;
    entry_t           rd_entry;
    logic             hit;
    logic             last_entry;
    logic             overflow;
    logic             finish;
    logic             has_res;
    logic             slot_free;
    logic             hold;

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign load_en   = accept && (cmd.opcode == OP_LOAD)
                    && ({{(32-INDEX_FIELD_W){1'b0}}, cmd.entry_index} < TABLE_ENTRIES);

    // Entry to store; the symbol is cut to its configured width.
    always_comb
    begin
        wr_entry.code   = cmd.entry_code;
        wr_entry.length = cmd.entry_length;
        wr_entry.symbol = cmd.entry_symbol & SYM_W'((1 << SYMBOL_BITS) - 1);
    end

    pctd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (load_en),
        .wr_addr (cmd.entry_index[IDX_W-1:0]),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    pctd_cmp u_cmp (
        .entry       (rd_entry),
        .entry_valid (valid_reg[cnt_reg]),
        .pending     (pend_reg),
        .hit         (hit)
    );

    // Scan decisions for the entry now at the RAM output.
    assign last_entry = (cnt_reg == IDX_W'(TABLE_ENTRIES - 1));
    assign overflow   = (pend_reg.length >= LEN_W'(MAX_CODE_LEN));
    assign finish     = (state_reg == S_SCAN) && (hit || last_entry);
    assign has_res    = hit || overflow || last_reg;
    assign slot_free  = !out_valid_reg || res.ready;
    assign hold       = finish && has_res && !slot_free;

    // Read address: first entry on a new bit, the same entry while held.
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            rd_addr = '0;
        end
        else if (hold)
        begin
            rd_addr = cnt_reg;
        end
        else
        begin
            rd_addr = cnt_reg + 1'b1;
        end
    end

    // Sequencer and result register.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        last_next      = last_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_sym_next   = out_sym_reg;
        out_stat_next  = out_stat_reg;
        out_eos_next   = out_eos_reg;

        if (load_en)
        begin
            valid_next[cmd.entry_index[IDX_W-1:0]] = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd.opcode == OP_DATA))
                begin
                    pend_next.bits   = {pend_reg.bits[CODE_W-2:0], cmd.data_bit};
                    pend_next.length = pend_reg.length + 1'b1;
                    last_next        = cmd.stream_last;
                    cnt_next         = '0;
                    state_next       = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!finish)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (!hold)
                begin
                    state_next = S_IDLE;
                    if (has_res)
                    begin
                        out_valid_next = 1'b1;
                        out_eos_next   = last_reg;
                        pend_next      = '0;
                        if (hit)
                        begin
                            out_sym_next  = rd_entry.symbol;
                            out_stat_next = STAT_SYMBOL;
                        end
                        else if (overflow)
                        begin
                            out_sym_next  = '0;
                            out_stat_next = STAT_OVERFLOW;
                        end
                        else
                        begin
                            out_sym_next  = '0;
                            out_stat_next = STAT_LEFTOVER;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= '0;
            last_reg      <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            last_reg      <= last_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        out_sym_reg  <= out_sym_next;
        out_stat_reg <= out_stat_next;
        out_eos_reg  <= out_eos_next;
    end

    assign res.valid         = out_valid_reg;
    assign res.symbol_out    = out_sym_reg;
    assign res.status        = out_stat_reg;
    assign res.end_of_stream = out_eos_reg;

endmodule

### sv/pctd_checker.sv
module pctd_checker
    import pctd_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                in_opcode,
    input logic                out_valid,
    input logic                out_ready,
    input logic [SYM_W-1:0]    out_symbol,
    input logic [STATUS_W-1:0] out_status,
    input logic                out_eos
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_symbol)
                                    && $stable(out_status) && $stable(out_eos))
        else $error("result changed while stalled");

    // A load transfer leaves the block ready in the next cycle.
    a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_opcode == OP_LOAD) |=> in_ready)
        else $error("load item did not complete in one cycle");

    // A data transfer starts a table scan, during which no item is taken.
    a_data_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_opcode == OP_DATA) |=> !in_ready)
        else $error("ready during table scan");

    // Only the three defined status codes appear.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_status == STAT_SYMBOL) || (out_status == STAT_OVERFLOW)
                      || (out_status == STAT_LEFTOVER))
        else $error("undefined status code");

    // A leftover report only comes from the final stream bit.
    a_leftover_eos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status == STAT_LEFTOVER) |-> out_eos)
        else $error("leftover report without end of stream");

endmodule

bind prefix_code_table_decoder_core pctd_checker u_pctd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (cmd.valid),
    .in_ready   (cmd.ready),
    .in_opcode  (cmd.opcode),
    .out_valid  (res.valid),
    .out_ready  (res.ready),
    .out_symbol (res.symbol_out),
    .out_status (res.status),
    .out_eos    (res.end_of_stream)
);

### sim/tb_prefix_code_table_decoder_core.sv
`timescale 1ns / 100ps

module tb_prefix_code_table_decoder_core;

    import pctd_pkg::*;

    localparam int ITEM_TARGET  = 600;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;

    // One command transfer as the block sees it.
    typedef struct packed {
        logic                     opcode;
        logic [INDEX_FIELD_W-1:0] entry_index;
        logic [LEN_W-1:0]         entry_length;
        logic [CODE_W-1:0]        entry_code;
        logic [SYM_W-1:0]         entry_symbol;
        logic                     data_bit;
        logic                     stream_last;
    } cmd_item_t;

    // One result transfer.
    typedef struct packed {
        logic [SYM_W-1:0]    symbol;
        logic [STATUS_W-1:0] status;
        logic                eos;
    } decode_result_t;

    // Tracks the code table and the pending codeword, and holds the decode
    // results still owed by the block in order.
    class decode_scoreboard;
        logic [CODE_W-1:0]  slot_code  [TABLE_ENTRIES];
        logic [LEN_W-1:0]   slot_len   [TABLE_ENTRIES];
        logic [SYM_W-1:0]   slot_sym   [TABLE_ENTRIES];
        bit                 slot_valid [TABLE_ENTRIES];
        logic [CODE_W-1:0]  shift_bits;
        int unsigned        shift_len;
        decode_result_t     owed_q[$];
        int unsigned        error_count;

        function new();
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                slot_code[i]  = '0;
                slot_len[i]   = '0;
                slot_sym[i]   = '0;
                slot_valid[i] = 1'b0;
            end
            shift_bits  = '0;
            shift_len   = 0;
            error_count = 0;
        endfunction

        function int unsigned pending();
            return owed_q.size();
        endfunction

        function void owe(logic [SYM_W-1:0] sym, logic [STATUS_W-1:0] st, logic eos);
            decode_result_t r;
            r.symbol = sym;
            r.status = st;
            r.eos    = eos;
            owed_q.push_back(r);
            shift_bits = '0;
            shift_len  = 0;
        endfunction

        // Apply one accepted command and work out the result it causes.
        function void note_input(cmd_item_t it);
            int unsigned mask;
            int unsigned len;
            if (it.opcode == OP_LOAD) begin
                if (int'(it.entry_index) < TABLE_ENTRIES) begin
                    slot_code[it.entry_index]  = it.entry_code;
                    slot_len[it.entry_index]   = it.entry_length;
                    slot_sym[it.entry_index]   = it.entry_symbol;
                    slot_valid[it.entry_index] = 1'b1;
                end
                return;
            end
            shift_bits = {shift_bits[CODE_W-2:0], it.data_bit};
            shift_len  = shift_len + 1;
            // The lowest matching slot wins; only the low length bits count.
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                len = slot_len[i];
                if (!slot_valid[i] || len == 0 || len > MAX_CODE_LEN || len != shift_len)
                    continue;
                mask = (32'd1 << len) - 32'd1;
                if ((32'(slot_code[i]) & mask) != 32'(shift_bits))
                    continue;
                owe(slot_sym[i], STAT_SYMBOL, it.stream_last);
                return;
            end
            if (shift_len >= MAX_CODE_LEN)
                owe('0, STAT_OVERFLOW, it.stream_last);
            else if (it.stream_last)
                owe('0, STAT_LEFTOVER, 1'b1);
        endfunction

        task report_mismatch(string what, int unsigned exp_v, int unsigned got_v);
            $display("%0t mismatch: %s expected %0d got %0d", $time, what, exp_v, got_v);
            error_count++;
        endtask

        // Compare one accepted result with the oldest owed one.
        task check_result(decode_result_t got);
            decode_result_t want;
            if (owed_q.size() == 0) begin
                report_mismatch("unexpected result, status", 0, got.status);
                return;
            end
            want = owed_q.pop_front();
            if (got.symbol !== want.symbol)
                report_mismatch("symbol_out", want.symbol, got.symbol);
            if (got.status !== want.status)
                report_mismatch("status", want.status, got.status);
            if (got.eos !== want.eos)
                report_mismatch("end_of_stream", want.eos, got.eos);
        endtask
    endclass

    logic clk;
    logic rst_n;

    pctd_in_if  cmd_if ();
    pctd_out_if res_if ();

    prefix_code_table_decoder_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if)
    );

    decode_scoreboard sb = new();

    // Stimulus-side copy of what has been loaded, used to build codewords.
    logic [CODE_W-1:0] gen_code  [TABLE_ENTRIES];
    logic [LEN_W-1:0]  gen_len   [TABLE_ENTRIES];
    bit                gen_valid [TABLE_ENTRIES];

    bit          src_no_idle;
    bit          sink_no_idle;
    int unsigned hold_requests;
    int unsigned items_sent;

    // Free-running clock.
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watch both channels for transfers.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cmd_if.valid && cmd_if.ready)
                sb.note_input({cmd_if.opcode, cmd_if.entry_index, cmd_if.entry_length,
                               cmd_if.entry_code, cmd_if.entry_symbol, cmd_if.data_bit,
                               cmd_if.stream_last});
            if (res_if.valid && res_if.ready)
                sb.check_result({res_if.symbol_out, res_if.status, res_if.end_of_stream});
        end
    end

    // Result receiver: random stalls per transfer, plus a long hold on request.
    initial begin : result_sink
        int unsigned stall;
        int unsigned holds_served;
        holds_served = 0;
        res_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            stall = sink_no_idle ? 0 : $urandom_range(0, 19);
            if (holds_served != hold_requests) begin
                holds_served++;
                stall = stall + LONG_HOLD;
            end
            if (stall != 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!res_if.valid);
        end
    end

    // Run limit.
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL prefix_code_table_decoder_core");
        $finish;
    end

    // Every field random; callers overwrite the ones that matter.
    function automatic cmd_item_t random_fill();
        cmd_item_t it;
        it.opcode       = 1'($urandom_range(0, 1));
        it.entry_index  = INDEX_FIELD_W'($urandom);
        it.entry_length = LEN_W'($urandom);
        it.entry_code   = CODE_W'($urandom);
        it.entry_symbol = SYM_W'($urandom);
        it.data_bit     = 1'($urandom_range(0, 1));
        it.stream_last  = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic cmd_item_t make_load(logic [INDEX_FIELD_W-1:0] idx,
                                            logic [LEN_W-1:0] len,
                                            logic [CODE_W-1:0] code,
                                            logic [SYM_W-1:0] sym);
        cmd_item_t it;
        it = random_fill();
        it.opcode       = OP_LOAD;
        it.entry_index  = idx;
        it.entry_length = len;
        it.entry_code   = code;
        it.entry_symbol = sym;
        return it;
    endfunction

    function automatic cmd_item_t make_data(logic b, logic last);
        cmd_item_t it;
        it = random_fill();
        it.opcode      = OP_DATA;
        it.data_bit    = b;
        it.stream_last = last;
        return it;
    endfunction

    // Mostly short codewords, some long, a few lengths that can never match.
    function automatic cmd_item_t random_load();
        int unsigned pick;
        logic [LEN_W-1:0] len;
        pick = $urandom_range(0, 19);
        if (pick < 13)
            len = LEN_W'($urandom_range(1, 6));
        else if (pick < 16)
            len = LEN_W'($urandom_range(7, MAX_CODE_LEN));
        else if (pick < 18)
            len = LEN_W'(MAX_CODE_LEN);
        else if (pick == 18)
            len = '0;
        else
            len = LEN_W'($urandom_range(MAX_CODE_LEN + 1, 31));
        return make_load(INDEX_FIELD_W'($urandom), len, CODE_W'($urandom), SYM_W'($urandom));
    endfunction

    // Offer one command after a random gap and wait for its transfer.
    task automatic send_item(cmd_item_t it);
        int unsigned gap;
        gap = src_no_idle ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.opcode       <= it.opcode;
        cmd_if.entry_index  <= it.entry_index;
        cmd_if.entry_length <= it.entry_length;
        cmd_if.entry_code   <= it.entry_code;
        cmd_if.entry_symbol <= it.entry_symbol;
        cmd_if.data_bit     <= it.data_bit;
        cmd_if.stream_last  <= it.stream_last;
        do @(posedge clk); while (!cmd_if.ready);
        if (it.opcode == OP_LOAD) begin
            gen_code[it.entry_index]  = it.entry_code;
            gen_len[it.entry_index]   = it.entry_length;
            gen_valid[it.entry_index] = 1'b1;
        end
        items_sent++;
    endtask

    // Stop offering until every owed result has been taken.
    task automatic wait_for_drain();
        cmd_if.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // Load a prefix-free unary code: slot i is i ones then a zero. Bits above
    // the length are random so that only the low bits may take part.
    task automatic load_unary_table();
        int unsigned mask;
        int unsigned value;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            mask  = (32'd1 << (i + 1)) - 32'd1;
            value = mask & ~32'd1;
            send_item(make_load(INDEX_FIELD_W'(i), LEN_W'(i + 1),
                                CODE_W'(($urandom & ~mask) | value), SYM_W'($urandom)));
        end
    endtask

    // Build a stream from loaded codewords mixed with noise, then send it.
    task automatic send_stream();
        bit          bits_q[$];
        int unsigned cand[$];
        int unsigned words;
        int unsigned slot;
        int unsigned n;
        int          k;
        bit          end_it;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (gen_valid[i] && gen_len[i] >= 1 && gen_len[i] <= MAX_CODE_LEN)
                cand.push_back(i);
        words = $urandom_range(1, 10);
        repeat (words) begin
            if (cand.size() == 0 || $urandom_range(0, 9) == 0) begin
                // Noise: a short burst, or a run of ones long enough to overflow.
                if ($urandom_range(0, 2) == 0) begin
                    repeat (MAX_CODE_LEN) bits_q.push_back(1'b1);
                end else begin
                    n = $urandom_range(1, 4);
                    repeat (n) bits_q.push_back(1'($urandom_range(0, 1)));
                end
            end else begin
                slot = cand[$urandom_range(0, cand.size() - 1)];
                for (k = gen_len[slot]; k > 0; k--)
                    bits_q.push_back(gen_code[slot][k-1]);
            end
        end
        // Sometimes the stream ends in the middle of a codeword.
        if (bits_q.size() > 1 && $urandom_range(0, 3) == 0)
            void'(bits_q.pop_back());
        end_it = ($urandom_range(0, 3) != 0);
        for (k = 0; k < bits_q.size(); k++) begin
            if ($urandom_range(0, 29) == 0)
                send_item(random_load());
            send_item(make_data(bits_q[k], end_it && (k == bits_q.size() - 1)));
        end
    endtask

    // Reset, directed items, random segments, then drain and verdict.
    initial begin : stimulus
        int unsigned seg;
        int unsigned n;
        rst_n               <= 1'b0;
        cmd_if.valid        <= 1'b0;
        cmd_if.opcode       <= OP_LOAD;
        cmd_if.entry_index  <= '0;
        cmd_if.entry_length <= '0;
        cmd_if.entry_code   <= '0;
        cmd_if.entry_symbol <= '0;
        cmd_if.data_bit     <= 1'b0;
        cmd_if.stream_last  <= 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            gen_code[i]  = '0;
            gen_len[i]   = '0;
            gen_valid[i] = 1'b0;
        end
        src_no_idle   = 1'b0;
        sink_no_idle  = 1'b0;
        hold_requests = 0;
        items_sent    = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Empty table: a lone final bit is left over.
        send_item(make_data(1'b1, 1'b1));
        // Two slots with the same one-bit codeword; the lower slot wins.
        send_item(make_load(4'd0, 5'd1, 16'hFFFE, 8'hFF));
        send_item(make_load(4'd1, 5'd1, 16'h0000, 8'h11));
        send_item(make_data(1'b0, 1'b0));
        // A full-length entry, then entries that can never match: zero length and lengths past the limit.
        send_item(make_load(4'd15, LEN_W'(MAX_CODE_LEN), 16'h7FFF, 8'h00));
        send_item(make_load(4'd2, 5'd0, 16'hFFFF, 8'h22));
        send_item(make_load(4'd3, 5'd31, 16'hFFFF, 8'h33));
        send_item(make_load(4'd4, LEN_W'(MAX_CODE_LEN + 1), 16'h0001, 8'h44));
        // Sixteen ones match nothing: overflow reported on the final bit.
        repeat (MAX_CODE_LEN - 1) send_item(make_data(1'b1, 1'b0));
        send_item(make_data(1'b1, 1'b1));

        seg = 0;
        while (items_sent < ITEM_TARGET) begin
            src_no_idle  = ($urandom_range(0, 4) == 0);
            sink_no_idle = ($urandom_range(0, 4) == 0);
            if (seg == 2 || seg == 9) begin
                // Receiver stalls long while data keeps coming.
                src_no_idle = 1'b1;
                hold_requests++;
            end
            if (seg == 5 || seg == 14)
                wait_for_drain();
            if ($urandom_range(0, 3) == 0) begin
                load_unary_table();
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) send_item(random_load());
            end
            send_stream();
            seg++;
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.error_count == 0 && sb.pending() == 0)
            $display("PASS prefix_code_table_decoder_core");
        else
            $display("FAIL prefix_code_table_decoder_core");
        $finish;
    end

endmodule

### prefix_code_table_decoder_core.f
sv/pctd_pkg.sv
sv/pctd_in_if.sv
sv/pctd_out_if.sv
sv/pctd_ram.sv
sv/pctd_cmp.sv
sv/prefix_code_table_decoder_core.sv
sv/pctd_checker.sv
sim/tb_prefix_code_table_decoder_core.sv
